// ===== hdl/binary_to_decimal_ascii_assert.svh =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii assertion macros
// Shared property forms for the converter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication
`define B2DA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b2da: same-cycle check failed");

// next-cycle implication
`define B2DA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b2da: next-cycle check failed");

`endif

// ===== hdl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// Widths and controller/datapath interface types for the converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int VALUE_WIDTH = 32;
  // decimal digits of the largest value: floor(W * log10(2)) + 1
  localparam int NUM_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
  localparam int CHAR_WIDTH  = 6;
  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  // '0' within the six-bit character field
  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'h30;

  typedef struct packed {
    logic load;
    logic conv;
    logic shift;
  } b2da_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic msd_zero;
    logic last_digit;
  } b2da_sts_t;

endpackage

// ===== hdl/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned binary to decimal ASCII digit stream, most significant first.
// ----------------------------------------------------------------------------
// Slave stream takes one 32-bit unsigned value per request; master stream
// returns one ASCII digit per request, tlast on the least significant digit.
// Leading zeros are dropped; zero gives a single '0'.
// One value at a time: s_axis_tready_o is high only while idle.
// After acceptance, shift-add-3 builds the BCD word (one bit per
// cycle through the shared adjust stage), then leading zeros are dropped
// one per cycle before the first digit is shown (up to 9 leading zeros).
// With no stall, the time from acceptance to the next acceptance does
// not depend on the digit count.
// A stalled receiver holds the current digit and tlast stable; the block
// waits in place and nothing is lost.
// Reset returns the sequencer to idle; any value in flight is dropped.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [31:0] value
  input  logic [b2da_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [5:0] digit_char, [7:6] zero
  output logic [b2da_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // last_digit
  output logic                                 m_axis_tlast_o
);
  import b2da_pkg::*;

  b2da_cmd_t             cmd;
  b2da_sts_t             sts;
  logic [CHAR_WIDTH-1:0] digit_char;

  b2da_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  b2da_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (s_axis_tdata_i[VALUE_WIDTH-1:0]),
    .sts_o        (sts),
    .digit_char_o (digit_char)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_W - CHAR_WIDTH)'(0), digit_char};
  assign m_axis_tlast_o = sts.last_digit;

`include "binary_to_decimal_ascii_assert.svh"

  `B2DA_ASSERT_IMP(a_no_overlap, s_axis_tready_o, !m_axis_tvalid_o)
  `B2DA_ASSERT_NXT(a_run_continues, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, m_axis_tvalid_o)
  `B2DA_ASSERT_NXT(a_run_ends_idle, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, s_axis_tready_o)
  `B2DA_ASSERT_IMP(a_digit_range, m_axis_tvalid_o, m_axis_tdata_o[3:0] <= 4'd9)

endmodule

// ===== hdl/b2da_dp.sv =====
// ----------------------------------------------------------------------------
// b2da_dp
// Double-dabble shift register, bit and digit counters and character output.
// ----------------------------------------------------------------------------
module b2da_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  b2da_pkg::b2da_cmd_t                   cmd_i,
  input  logic [b2da_pkg::VALUE_WIDTH-1:0]      value_i,
  output b2da_pkg::b2da_sts_t                   sts_o,
  output logic [b2da_pkg::CHAR_WIDTH-1:0]       digit_char_o
);
  import b2da_pkg::*;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_WIDTH-1:0]   bcd_q, bcd_d, adj;
  logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]   dig_cnt_q, dig_cnt_d;
  logic [3:0]             msd;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    if (cmd_i.load) begin
      bin_d     = value_i;
      bcd_d     = '0;
      bit_cnt_d = BIT_CNT_W'(VALUE_WIDTH);
      dig_cnt_d = DIG_CNT_W'(NUM_DIGITS);
    end else if (cmd_i.conv) begin
      bin_d     = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      bcd_d     = {adj[BCD_WIDTH-2:0], bin_q[VALUE_WIDTH-1]};
      bit_cnt_d = bit_cnt_q - BIT_CNT_W'(1);
    end else if (cmd_i.shift) begin
      bcd_d     = {bcd_q[BCD_WIDTH-5:0], 4'd0};
      dig_cnt_d = dig_cnt_q - DIG_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
    end else begin
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign msd              = bcd_q[BCD_WIDTH-1 -: 4];
  assign sts_o.conv_last  = (bit_cnt_q == BIT_CNT_W'(1));
  assign sts_o.msd_zero   = (msd == 4'd0);
  assign sts_o.last_digit = (dig_cnt_q == DIG_CNT_W'(1));
  assign digit_char_o     = ASCII_ZERO | {2'b00, msd};

endmodule

// ===== hdl/b2da_ctrl.sv =====
// ----------------------------------------------------------------------------
// b2da_ctrl
// Sequencer: load, convert, drop leading zeros, emit digits.
// ----------------------------------------------------------------------------
module b2da_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  input  b2da_pkg::b2da_sts_t  sts_i,
  output b2da_pkg::b2da_cmd_t  cmd_o
);
  import b2da_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.load  = 1'b0;
    cmd_o.conv  = 1'b0;
    cmd_o.shift = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (sts_i.conv_last) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts_i.msd_zero && !sts_i.last_digit) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (m_tready_i) begin
          cmd_o.shift = 1'b1;
          if (sts_i.last_digit) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = (state_q == ST_EMIT);

endmodule
